[rtl/llpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package llpf_pkg;

  // Number of text bytes the store can take; a text that reaches it overflows.
  localparam int TEXT_CAPACITY = 32768;
  localparam int ADDR_W        = $clog2(TEXT_CAPACITY);
  localparam int CNT_W         = $clog2(TEXT_CAPACITY + 1);
  localparam int LETTER_W      = 5;
  localparam int OFFSET_W      = 15;
  localparam int LENGTH_W      = 16;

  function automatic logic [LETTER_W-1:0] fold_letter(input logic [7:0] b);
    logic [7:0] low;
    low = (b | 8'h20) - 8'h61;
    return low[LETTER_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/longest_letter_palindrome_finder_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Longest letter palindrome finder. Text bytes come in one transaction per
// cycle (start while busy is low). Letters are folded to lower case and
// stored with their byte offset; a zero byte ends the scan, later bytes only
// count toward capacity. The byte with last_i set closes the text: busy
// rises and the block expands around every letter center (odd centers, then
// even), keeping a candidate only if strictly longer than the best so far.
// The result appears for exactly one cycle with valid_o high; the receiver
// cannot stall it, so it must sample it in that cycle. Overflow (the text
// reached TEXT_CAPACITY bytes) reports overflow_o = 1 and zero elsewhere.
// Search steps: each letter-pair compare does a registered two-port read of
// the letter store, then uses the shared compare/step unit. Each center also
// has a setup step and a best-length compare; the switch from odd to even
// centers and the final center check are steps of their own, and the
// offsets are fetched at the end. An overflowed text skips the search. busy
// falls in the cycle valid_o is shown, so a new text may start there.

module longest_letter_palindrome_finder_core
  import llpf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [7:0]          text_byte_i,
  input  wire logic                last_i,
  output logic                     valid_o,
  output logic [LENGTH_W-1:0]      best_length_o,
  output logic [OFFSET_W-1:0]      start_offset_o,
  output logic [OFFSET_W-1:0]      end_offset_o,
  output logic                     overflow_o
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_CENTER = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_OFFS   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  localparam logic [CNT_W-1:0] CAP = CNT_W'(TEXT_CAPACITY);

  // Stores: letter codes and original byte offsets, indexed by letter number.
  logic [LETTER_W-1:0] letter_mem [TEXT_CAPACITY];
  logic [ADDR_W-1:0]   offset_mem [TEXT_CAPACITY];

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    byte_count_q, byte_count_d;
  logic [CNT_W-1:0]    letter_count_q, letter_count_d;
  logic                scan_ended_q, scan_ended_d;
  logic                ovf_q, ovf_d;
  logic                phase_q, phase_d;       // 0: odd centers, 1: even
  logic [CNT_W-1:0]    center_q, center_d;
  logic [ADDR_W-1:0]   a_q, a_d, b_q, b_d;     // pair under test
  logic [ADDR_W-1:0]   lo_q, lo_d, hi_q, hi_d; // current palindrome
  logic                cur_valid_q, cur_valid_d;
  logic [CNT_W-1:0]    best_q, best_d;
  logic [ADDR_W-1:0]   best_lo_q, best_lo_d, best_hi_q, best_hi_d;
  logic [LETTER_W-1:0] rd_a_q, rd_b_q;
  logic [ADDR_W-1:0]   off_l_q, off_r_q;

  logic                valid_q, valid_d;
  logic [LENGTH_W-1:0] len_q, len_d;
  logic [OFFSET_W-1:0] so_q, so_d, eo_q, eo_d;
  logic                ovo_q, ovo_d;

  logic                accept;
  logic                is_letter;
  logic                wr_en;
  logic [CNT_W-1:0]    cur_len;
  logic [CNT_W-1:0]    b_next;
  logic [CNT_W-1:0]    c_next;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_LOAD);
  assign cur_len = cur_valid_q ? (CNT_W'(hi_q) - CNT_W'(lo_q) + CNT_W'(1)) : '0;
  assign b_next  = CNT_W'(b_q) + CNT_W'(1);
  assign c_next  = center_q + CNT_W'(1);

  always_comb begin
    is_letter = text_byte_i inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  end

  assign wr_en = accept && (byte_count_q < CAP) && !scan_ended_q &&
                 (text_byte_i != 8'h00) && is_letter;

  always_comb begin
    state_d        = state_q;
    byte_count_d   = byte_count_q;
    letter_count_d = letter_count_q;
    scan_ended_d   = scan_ended_q;
    ovf_d          = ovf_q;
    phase_d        = phase_q;
    center_d       = center_q;
    a_d            = a_q;
    b_d            = b_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    cur_valid_d    = cur_valid_q;
    best_d         = best_q;
    best_lo_d      = best_lo_q;
    best_hi_d      = best_hi_q;
    valid_d        = 1'b0;
    len_d          = len_q;
    so_d           = so_q;
    eo_d           = eo_q;
    ovo_d          = ovo_q;

    case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (byte_count_q < CAP) begin
            byte_count_d = byte_count_q + CNT_W'(1);
            if (!scan_ended_q && text_byte_i == 8'h00) begin
              scan_ended_d = 1'b1;
            end
          end
          if (wr_en) begin
            letter_count_d = letter_count_q + CNT_W'(1);
          end
          if (last_i) begin
            ovf_d    = (byte_count_d >= CAP);
            best_d   = '0;
            phase_d  = 1'b0;
            center_d = '0;
            state_d  = ovf_d ? S_OUT : S_CENTER;
          end
        end
      end

      S_CENTER: begin
        if (!phase_q) begin
          if (center_q < letter_count_q) begin
            lo_d        = center_q[ADDR_W-1:0];
            hi_d        = center_q[ADDR_W-1:0];
            cur_valid_d = 1'b1;
            if (center_q != '0 && c_next < letter_count_q) begin
              a_d     = center_q[ADDR_W-1:0] - ADDR_W'(1);
              b_d     = c_next[ADDR_W-1:0];
              state_d = S_READ;
            end else begin
              state_d = S_FIN;
            end
          end else begin
            phase_d  = 1'b1;
            center_d = '0;
          end
        end else begin
          if (c_next < letter_count_q) begin
            cur_valid_d = 1'b0;
            a_d         = center_q[ADDR_W-1:0];
            b_d         = c_next[ADDR_W-1:0];
            state_d     = S_READ;
          end else begin
            state_d = S_OFFS;
          end
        end
      end

      S_READ: begin
        state_d = S_CMP;
      end

      S_CMP: begin
        if (rd_a_q == rd_b_q) begin
          lo_d        = a_q;
          hi_d        = b_q;
          cur_valid_d = 1'b1;
          if (a_q != '0 && b_next < letter_count_q) begin
            a_d     = a_q - ADDR_W'(1);
            b_d     = b_next[ADDR_W-1:0];
            state_d = S_READ;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (cur_len > best_q) begin
          best_d    = cur_len;
          best_lo_d = lo_q;
          best_hi_d = hi_q;
        end
        center_d = c_next;
        state_d  = S_CENTER;
      end

      S_OFFS: begin
        state_d = S_OUT;
      end

      S_OUT: begin
        valid_d        = 1'b1;
        len_d          = LENGTH_W'(best_q);
        so_d           = (best_q != '0) ? OFFSET_W'(off_l_q) : '0;
        eo_d           = (best_q != '0) ? OFFSET_W'(off_r_q) : '0;
        ovo_d          = ovf_q;
        byte_count_d   = '0;
        letter_count_d = '0;
        scan_ended_d   = 1'b0;
        state_d        = S_LOAD;
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_LOAD;
      byte_count_q   <= '0;
      letter_count_q <= '0;
      scan_ended_q   <= 1'b0;
      valid_q        <= 1'b0;
    end else begin
      state_q        <= state_d;
      byte_count_q   <= byte_count_d;
      letter_count_q <= letter_count_d;
      scan_ended_q   <= scan_ended_d;
      valid_q        <= valid_d;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    ovf_q       <= ovf_d;
    phase_q     <= phase_d;
    center_q    <= center_d;
    a_q         <= a_d;
    b_q         <= b_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    cur_valid_q <= cur_valid_d;
    best_q      <= best_d;
    best_lo_q   <= best_lo_d;
    best_hi_q   <= best_hi_d;
    len_q       <= len_d;
    so_q        <= so_d;
    eo_q        <= eo_d;
    ovo_q       <= ovo_d;
  end

  // Letter store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      letter_mem[letter_count_q[ADDR_W-1:0]] <= fold_letter(text_byte_i);
    end
    if (state_q == S_READ) begin
      rd_a_q <= letter_mem[a_q];
      rd_b_q <= letter_mem[b_q];
    end
  end

  // Offset store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      offset_mem[letter_count_q[ADDR_W-1:0]] <= byte_count_q[ADDR_W-1:0];
    end
    if (state_q == S_OFFS) begin
      off_l_q <= offset_mem[best_lo_q];
      off_r_q <= offset_mem[best_hi_q];
    end
  end

  assign valid_o        = valid_q;
  assign best_length_o  = len_q;
  assign start_offset_o = so_q;
  assign end_offset_o   = eo_q;
  assign overflow_o     = ovo_q;

  // The result strobe lasts one cycle.
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  // Closing a text starts the search.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy)
    else $error("last byte did not start the search");

  // An overflowed text reports no palindrome.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && overflow_o) |-> (best_length_o == '0))
    else $error("overflow result carries a length");

  // No palindrome means zero offsets.
  a_empty_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && best_length_o == '0) |-> (start_offset_o == '0 && end_offset_o == '0))
    else $error("empty result carries offsets");

endmodule

`default_nettype wire

[dv/tb_longest_letter_palindrome_finder_core.sv]
`timescale 1ns / 1ps

module tb_longest_letter_palindrome_finder_core;
  import llpf_pkg::*;

  // Generous run limit for the whole simulation.
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned RANDOM_BYTES = 1750;

  // Idle styles for the byte sender, chosen per text.
  typedef enum int {
    GAPS_NONE,
    GAPS_FULL,
    GAPS_RARE
  } gap_style_e;

  // One text byte as the sender presents it, with the idle cycles before it.
  typedef struct {
    logic [7:0]  data;
    logic        fin;
    int unsigned gap;
  } byte_txn_t;

  // Expected outcome of one text.
  typedef struct {
    logic [LENGTH_W-1:0] length;
    logic [OFFSET_W-1:0] first_off;
    logic [OFFSET_W-1:0] last_off;
    logic                ovf;
  } palin_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic [7:0]          text_byte_i = '0;
  logic                last_i      = 1'b0;
  logic                busy;
  logic                valid_o;
  logic [LENGTH_W-1:0] best_length_o;
  logic [OFFSET_W-1:0] start_offset_o;
  logic [OFFSET_W-1:0] end_offset_o;
  logic                overflow_o;

  longest_letter_palindrome_finder_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .text_byte_i    (text_byte_i),
    .last_i         (last_i),
    .valid_o        (valid_o),
    .best_length_o  (best_length_o),
    .start_offset_o (start_offset_o),
    .end_offset_o   (end_offset_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the letter and offset stores
  // ---------------------------------------------------------------------------
  logic [4:0]          letter_mem [0:TEXT_CAPACITY-1];
  logic [OFFSET_W-1:0] offset_mem [0:TEXT_CAPACITY-1];
  int unsigned         bytes_seen;
  int unsigned         letters_kept;
  bit                  scan_done;

  byte_txn_t     pending_bytes [$];  // bytes still to be sent
  palin_result_t results_due [$];    // one entry per closed text, oldest first
  logic [7:0]    text_buf [$];       // text under construction
  int unsigned   mismatches;
  int unsigned   cycle_cnt;
  int unsigned   idle_left;
  int unsigned   random_bytes;
  byte_txn_t     nxt_txn;

  // Grow a palindrome outward from the span lo..hi, which already matches.
  function automatic void widen(inout int lo, inout int hi);
    while (lo > 0 && hi + 1 < int'(letters_kept) && letter_mem[lo-1] == letter_mem[hi+1]) begin
      lo--;
      hi++;
    end
  endfunction

  // Odd centers first, then even; only a strictly longer span replaces the best,
  // so a tie keeps the candidate found first (odd centers before even).
  function automatic palin_result_t search_palindrome();
    palin_result_t res;
    int best, bl, br, lo, hi, c;
    best = 0;
    bl = 0;
    br = 0;
    for (c = 0; c < int'(letters_kept); c++) begin
      lo = c;
      hi = c;
      widen(lo, hi);
      if (hi - lo + 1 > best) begin
        best = hi - lo + 1;
        bl = lo;
        br = hi;
      end
    end
    for (c = 0; c + 1 < int'(letters_kept); c++) begin
      if (letter_mem[c] == letter_mem[c+1]) begin
        lo = c;
        hi = c + 1;
        widen(lo, hi);
        if (hi - lo + 1 > best) begin
          best = hi - lo + 1;
          bl = lo;
          br = hi;
        end
      end
    end
    res.length    = best[LENGTH_W-1:0];
    res.first_off = (best > 0) ? offset_mem[bl] : '0;
    res.last_off  = (best > 0) ? offset_mem[br] : '0;
    res.ovf       = 1'b0;
    return res;
  endfunction

  // Apply one accepted byte; on the closing byte queue the expected result.
  task automatic absorb_byte(input logic [7:0] data, input logic fin);
    palin_result_t res;
    bit is_letter;
    is_letter = (data >= 8'h41 && data <= 8'h5a) || (data >= 8'h61 && data <= 8'h7a);
    if (bytes_seen < TEXT_CAPACITY) begin
      if (!scan_done) begin
        if (data == 8'h00) begin
          scan_done = 1'b1;
        end else if (is_letter && letters_kept < TEXT_CAPACITY) begin
          // 'A' and 'a' both carry 5'h01 in their low bits
          letter_mem[letters_kept] = data[4:0] - 5'd1;
          offset_mem[letters_kept] = bytes_seen[OFFSET_W-1:0];
          letters_kept++;
        end
      end
      bytes_seen++;
    end
    if (fin) begin
      if (bytes_seen >= TEXT_CAPACITY) begin
        res = '{length: '0, first_off: '0, last_off: '0, ovf: 1'b1};
      end else begin
        res = search_palindrome();
      end
      results_due.push_back(res);
      bytes_seen = 0;
      letters_kept = 0;
      scan_done = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap(gap_style_e style);
    case (style)
      GAPS_NONE: return 0;
      GAPS_FULL: return $urandom_range(0, 19);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  // Any nonzero byte that is not a letter.
  function automatic logic [7:0] pick_filler();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a));
    return b;
  endfunction

  function automatic logic [7:0] letter_byte(int unsigned code);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + code[7:0];
  endfunction

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Move the built text into the send queue, marking its closing byte.
  task automatic send_text(input gap_style_e style);
    byte_txn_t t;
    for (int i = 0; i < text_buf.size(); i++) begin
      t.data = text_buf[i];
      t.fin  = (i == text_buf.size() - 1);
      t.gap  = draw_gap(style);
      pending_bytes.push_back(t);
    end
    text_buf.delete();
  endtask

  // Letters around a mirrored core over a small alphabet, with filler and the
  // occasional zero byte sprinkled in.
  task automatic build_palin_text();
    int unsigned codes [$];
    int unsigned half [$];
    int unsigned alpha, base, core_len, zero_at;
    alpha = $urandom_range(1, 3);
    base = $urandom_range(0, 23);
    core_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 8);
    repeat ($urandom_range(0, 4)) codes.push_back($urandom_range(0, 25));
    repeat (core_len) half.push_back(base + $urandom_range(0, alpha - 1));
    foreach (half[i]) codes.push_back(half[i]);
    if ($urandom_range(0, 1)) codes.push_back(base + $urandom_range(0, alpha - 1));
    for (int i = half.size() - 1; i >= 0; i--) codes.push_back(half[i]);
    repeat ($urandom_range(0, 4)) codes.push_back($urandom_range(0, 25));
    if (codes.size() == 0) codes.push_back($urandom_range(0, 25));
    zero_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, codes.size()) : codes.size() + 1;
    foreach (codes[i]) begin
      if (i == zero_at) text_buf.push_back(8'h00);
      if ($urandom_range(0, 3) == 0) text_buf.push_back(pick_filler());
      text_buf.push_back(letter_byte(codes[i]));
    end
    if (zero_at == codes.size()) text_buf.push_back(8'h00);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes, honoring the idle count drawn for each
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      text_byte_i <= '0;
      last_i      <= 1'b0;
      idle_left    = 0;
    end else begin
      if (start && !busy) absorb_byte(text_byte_i, last_i);
      if (start && busy) begin
        // hold the current byte until the block takes it
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_bytes.size() > 0 && pending_bytes[0].gap > 0) begin
        idle_left = pending_bytes[0].gap - 1;
        pending_bytes[0].gap = 0;
        start <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        nxt_txn = pending_bytes.pop_front();
        start       <= 1'b1;
        text_byte_i <= nxt_txn.data;
        last_i      <= nxt_txn.fin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt++;
      if (valid_o) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual length %0d ovf %0b",
                   $time, best_length_o, overflow_o);
          mismatches++;
        end else begin
          check_field("best_length", results_due[0].length, best_length_o);
          check_field("start_offset", results_due[0].first_off, start_offset_o);
          check_field("end_offset", results_due[0].last_off, end_offset_o);
          check_field("overflow", results_due[0].ovf, overflow_o);
          void'(results_due.pop_front());
        end
      end
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches   = 0;
    cycle_cnt    = 0;
    bytes_seen   = 0;
    letters_kept = 0;
    scan_done    = 1'b0;
    random_bytes = 0;

    // Directed: letter extremes, case folding, empty text, non-letters that
    // border the letter ranges, a zero byte ending the scan, and a tie.
    put_str("A");
    send_text(GAPS_NONE);
    put_str("Zz");
    send_text(GAPS_FULL);
    text_buf.push_back(8'h00);
    send_text(GAPS_NONE);
    put_str("@[`{");
    text_buf.push_back(8'hff);
    put_str("b");
    send_text(GAPS_RARE);
    put_str("ab");
    text_buf.push_back(8'h00);
    put_str("ba");
    send_text(GAPS_NONE);
    put_str("abab");
    send_text(GAPS_FULL);

    // Capacity: one byte short of it, exactly at it, and past it with a zero
    // byte early. Mostly filler keeps the search short.
    put_str("xyz");
    while (text_buf.size() < TEXT_CAPACITY - 8) text_buf.push_back(pick_filler());
    put_str("RaCecaR");
    send_text(GAPS_NONE);
    put_str("abba");
    while (text_buf.size() < TEXT_CAPACITY) text_buf.push_back(pick_filler());
    send_text(GAPS_NONE);
    put_str("ab");
    text_buf.push_back(8'h00);
    while (text_buf.size() < TEXT_CAPACITY + 3) text_buf.push_back(8'($urandom_range(0, 255)));
    send_text(GAPS_NONE);
    put_str("noon");
    send_text(GAPS_RARE);

    // Random texts: mostly letter-rich with palindromic cores, some raw noise.
    while (random_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) < 7) begin
        build_palin_text();
      end else begin
        repeat ($urandom_range(1, 30)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      random_bytes += text_buf.size();
      send_text(gap_style_e'($urandom_range(0, 2)));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() != 0 || start || results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/llpf_pkg.sv
rtl/longest_letter_palindrome_finder_core.sv
dv/tb_longest_letter_palindrome_finder_core.sv
